// File: design/wlf_pkg.sv
// package for the weighted line fit: widths, arithmetic unit codes and the fit microprogram
// no dependencies
package wlf_pkg;

  localparam int MAX_POINTS       = 1024;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int CNT_W            = $clog2(MAX_POINTS + 1);
  localparam int WQ_W             = WEIGHT_FRAC_BITS + 1;
  localparam int SUM_W            = 64;
  localparam int FIT_W            = 168;
  localparam int ADD_W            = FIT_W + 2;
  localparam int FCNT_W           = $clog2(FIT_W + 1);
  localparam int ROOT_STEPS       = 32;
  localparam int PROG_LEN         = 26;
  localparam int PC_W             = $clog2(PROG_LEN);

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_ABS,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_S,
    SRC_SX,
    SRC_SY,
    SRC_SXX,
    SRC_SXY,
    SRC_SYY,
    SRC_D,
    SRC_NA,
    SRC_NB,
    SRC_C,
    SRC_T,
    SRC_U,
    SRC_T_RND,
    SRC_D_X2,
    SRC_SXX_SC,
    SRC_S_SC,
    SRC_C_SC,
    SRC_D_SC,
    SRC_NM2,
    SRC_T_SAT64
  } src_t;

  typedef enum logic [3:0] {
    DST_T,
    DST_U,
    DST_D,
    DST_NA,
    DST_NB,
    DST_C,
    DST_INT,
    DST_SLP,
    DST_ERA,
    DST_ERB,
    DST_CHI
  } dst_t;

  typedef struct packed {
    alu_op_t op;
    src_t    a;
    src_t    b;
    dst_t    dst;
  } uop_t;

  function automatic uop_t mk_uop(alu_op_t o, src_t a, src_t b, dst_t d);
    uop_t u;
    u.op  = o;
    u.a   = a;
    u.b   = b;
    u.dst = d;
    return u;
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      PC_W'(0):  u = mk_uop(OP_MUL,  SRC_S,       SRC_SXX,  DST_T);
      PC_W'(1):  u = mk_uop(OP_MUL,  SRC_SX,      SRC_SX,   DST_U);
      PC_W'(2):  u = mk_uop(OP_SUB,  SRC_T,       SRC_U,    DST_D);
      PC_W'(3):  u = mk_uop(OP_MUL,  SRC_SXX,     SRC_SY,   DST_T);
      PC_W'(4):  u = mk_uop(OP_MUL,  SRC_SX,      SRC_SXY,  DST_U);
      PC_W'(5):  u = mk_uop(OP_SUB,  SRC_T,       SRC_U,    DST_NA);
      PC_W'(6):  u = mk_uop(OP_MUL,  SRC_S,       SRC_SXY,  DST_T);
      PC_W'(7):  u = mk_uop(OP_MUL,  SRC_SX,      SRC_SY,   DST_U);
      PC_W'(8):  u = mk_uop(OP_SUB,  SRC_T,       SRC_U,    DST_NB);
      PC_W'(9):  u = mk_uop(OP_ABS,  SRC_NA,      SRC_ZERO, DST_T);
      PC_W'(10): u = mk_uop(OP_ADD,  SRC_T_RND,   SRC_D,    DST_T);
      PC_W'(11): u = mk_uop(OP_DIV,  SRC_T,       SRC_D_X2, DST_INT);
      PC_W'(12): u = mk_uop(OP_ABS,  SRC_NB,      SRC_ZERO, DST_T);
      PC_W'(13): u = mk_uop(OP_ADD,  SRC_T_RND,   SRC_D,    DST_T);
      PC_W'(14): u = mk_uop(OP_DIV,  SRC_T,       SRC_D_X2, DST_SLP);
      PC_W'(15): u = mk_uop(OP_DIV,  SRC_SXX_SC,  SRC_D,    DST_T);
      PC_W'(16): u = mk_uop(OP_SQRT, SRC_T_SAT64, SRC_ZERO, DST_ERA);
      PC_W'(17): u = mk_uop(OP_DIV,  SRC_S_SC,    SRC_D,    DST_T);
      PC_W'(18): u = mk_uop(OP_SQRT, SRC_T_SAT64, SRC_ZERO, DST_ERB);
      PC_W'(19): u = mk_uop(OP_MUL,  SRC_SYY,     SRC_D,    DST_T);
      PC_W'(20): u = mk_uop(OP_MUL,  SRC_NA,      SRC_SY,   DST_U);
      PC_W'(21): u = mk_uop(OP_SUB,  SRC_T,       SRC_U,    DST_C);
      PC_W'(22): u = mk_uop(OP_MUL,  SRC_NB,      SRC_SXY,  DST_U);
      PC_W'(23): u = mk_uop(OP_SUB,  SRC_C,       SRC_U,    DST_C);
      PC_W'(24): u = mk_uop(OP_MUL,  SRC_D_SC,    SRC_NM2,  DST_U);
      PC_W'(25): u = mk_uop(OP_DIV,  SRC_C_SC,    SRC_U,    DST_CHI);
      default:   u = mk_uop(OP_ADD,  SRC_ZERO,    SRC_ZERO, DST_T);
    endcase
    return u;
  endfunction

endpackage

// File: design/wlf_if.sv
// point and fit result channels of the weighted line fit
// depends on wlf_pkg
interface wlf_in_if import wlf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic [15:0]        y_uncertainty;
  logic               end_of_event;

  modport source (output valid, x_value, y_value, y_uncertainty, end_of_event, input ready);
  modport sink (input valid, x_value, y_value, y_uncertainty, end_of_event, output ready);
endinterface

interface wlf_out_if import wlf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] intercept;
  logic signed [31:0] slope;
  logic [31:0]        intercept_error;
  logic [31:0]        slope_error;
  logic [39:0]        chi2_per_dof;
  logic [15:0]        event_number;
  logic [CNT_W-1:0]   points_in_event;
  logic               fit_valid;

  modport source (output valid, intercept, slope, intercept_error, slope_error, chi2_per_dof,
                  event_number, points_in_event, fit_valid, input ready);
  modport sink (input valid, intercept, slope, intercept_error, slope_error, chi2_per_dof,
                event_number, points_in_event, fit_valid, output ready);
endinterface

// File: design/wlf_alu.sv
// shared iterative wide unit: add, subtract, absolute value, shift-add multiply,
// restoring divide and bitwise square root; depends on wlf_pkg
module wlf_alu import wlf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  alu_req_t         req,
  input  logic [FIT_W-1:0] opa,
  input  logic [FIT_W-1:0] opb,
  output alu_stat_t        stat,
  output logic [FIT_W-1:0] result
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  alu_op_t           op_r;
  logic [FCNT_W-1:0] cnt_r;
  logic [FIT_W-1:0]  acc_r;
  logic [FIT_W-1:0]  xr_r;
  logic [FIT_W-1:0]  yr_r;
  logic [ADD_W-1:0]  add_a;
  logic [ADD_W-1:0]  add_b;
  logic              add_sub;
  logic [ADD_W-1:0]  add_y;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (op_r)
      OP_ADD: begin
        add_a = {2'b00, xr_r};
        add_b = {2'b00, yr_r};
      end
      OP_SUB: begin
        add_a   = {2'b00, xr_r};
        add_b   = {2'b00, yr_r};
        add_sub = 1'b1;
      end
      OP_ABS: begin
        if (xr_r[FIT_W-1]) begin
          add_b   = {2'b00, xr_r};
          add_sub = 1'b1;
        end else begin
          add_a = {2'b00, xr_r};
        end
      end
      OP_MUL: begin
        add_a = {2'b00, acc_r};
        add_b = yr_r[0] ? {2'b00, xr_r} : '0;
      end
      OP_DIV: begin
        add_a   = {1'b0, acc_r, xr_r[FIT_W-1]};
        add_b   = {2'b00, yr_r};
        add_sub = 1'b1;
      end
      OP_SQRT: begin
        add_a   = {yr_r, xr_r[63:62]};
        add_b   = {acc_r, 2'b01};
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_y = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == FCNT_W'(1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (req.start) begin
        op_r <= req.op;
        unique case (req.op)
          OP_MUL, OP_DIV: cnt_r <= FCNT_W'(FIT_W);
          OP_SQRT:        cnt_r <= FCNT_W'(ROOT_STEPS);
          default:        cnt_r <= FCNT_W'(1);
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      xr_r  <= opa;
      yr_r  <= (req.op == OP_SQRT) ? '0 : opb;
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_r <= add_y[FIT_W-1:0];
          xr_r  <= {xr_r[FIT_W-2:0], 1'b0};
          yr_r  <= {1'b0, yr_r[FIT_W-1:1]};
        end
        OP_DIV: begin
          if (!add_y[ADD_W-1]) begin
            acc_r <= add_y[FIT_W-1:0];
            xr_r  <= {xr_r[FIT_W-2:0], 1'b1};
          end else begin
            acc_r <= {acc_r[FIT_W-2:0], xr_r[FIT_W-1]};
            xr_r  <= {xr_r[FIT_W-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          if (!add_y[ADD_W-1]) begin
            yr_r  <= add_y[FIT_W-1:0];
            acc_r <= {acc_r[FIT_W-2:0], 1'b1};
          end else begin
            yr_r  <= {yr_r[FIT_W-3:0], xr_r[63:62]};
            acc_r <= {acc_r[FIT_W-2:0], 1'b0};
          end
          xr_r <= {xr_r[FIT_W-3:0], 2'b00};
        end
        default: acc_r <= add_y[FIT_W-1:0];
      endcase
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = (op_r == OP_DIV) ? xr_r : acc_r;

endmodule

// File: design/weighted_line_fit.sv
// weighted line fit top level: point accumulation and fit sequencer
// a point without end mark passes the square, product, 17-step weight divider and accumulate states; ready stays low
// closing an event runs the fit microprogram on wlf_alu, with 15 multiply and divide passes among its steps
// one transaction at a time; the next point is taken while a result waits on the output register
// synchronous active-low reset clears the sums, counters, sequencer and output valid
module weighted_line_fit import wlf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wlf_in_if.sink     in_pt,
  wlf_out_if.source  out_fit
);

  localparam int PMA_W  = (WQ_W + 1 > 17) ? WQ_W + 1 : 17;
  localparam int PMB_W  = 33;
  localparam int PRD_W  = PMA_W + PMB_W;
  localparam int STEP_W = $clog2(WQ_W + 8);
  localparam int SUM_N  = 6;

  localparam logic [2:0] SUM_S   = 3'd0;
  localparam logic [2:0] SUM_SX  = 3'd1;
  localparam logic [2:0] SUM_SY  = 3'd2;
  localparam logic [2:0] SUM_SXX = 3'd3;
  localparam logic [2:0] SUM_SXY = 3'd4;
  localparam logic [2:0] SUM_SYY = 3'd5;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQ    = 8'b0000_0010,
    ST_PROD  = 8'b0000_0100,
    ST_WDIV  = 8'b0000_1000,
    ST_ACC   = 8'b0001_0000,
    ST_ISSUE = 8'b0010_0000,
    ST_WAIT  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [STEP_W-1:0]         step_r;
  logic [PC_W-1:0]           pc_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [15:0]               evt_r;
  logic signed [15:0]        xv_r, yv_r;
  logic [15:0]               uv_r;
  logic                      eoe_r;
  logic [31:0]               u2_r;
  logic signed [PMB_W-1:0]   xx_r, xy_r, yy_r;
  logic [31:0]               wrem_r;
  logic [WQ_W-1:0]           wq_r;
  logic signed [PRD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]   sum_r [SUM_N];
  logic [FIT_W-1:0]          d_r, na_r, nb_r, c_r, tmp_a_r, tmp_b_r;
  logic [31:0]               ia_r, sl_r, ea_r, eb_r;
  logic [39:0]               chi_r;
  logic                      ov_r;

  logic signed [PMA_W-1:0]   pm_a;
  logic signed [PMB_W-1:0]   pm_b;
  logic signed [PRD_W-1:0]   pm_p;
  logic [31:0]               wnum;
  logic [32:0]               wsh;
  logic [33:0]               wdf;
  logic [2:0]                acc_idx;
  logic                      full;
  logic                      fit_ok;
  logic                      out_load;
  uop_t                      uop;
  alu_req_t                  alu_req;
  alu_stat_t                 alu_st;
  logic [FIT_W-1:0]          alu_a, alu_b, alu_res;

  function automatic logic [FIT_W-1:0] ext_sum(input logic signed [SUM_W-1:0] s);
    return {{(FIT_W-SUM_W){s[SUM_W-1]}}, s};
  endfunction

  function automatic logic [FIT_W-1:0] src_val(input src_t s);
    logic [FIT_W-1:0] v;
    case (s)
      SRC_S:       v = ext_sum(sum_r[SUM_S]);
      SRC_SX:      v = ext_sum(sum_r[SUM_SX]);
      SRC_SY:      v = ext_sum(sum_r[SUM_SY]);
      SRC_SXX:     v = ext_sum(sum_r[SUM_SXX]);
      SRC_SXY:     v = ext_sum(sum_r[SUM_SXY]);
      SRC_SYY:     v = ext_sum(sum_r[SUM_SYY]);
      SRC_D:       v = d_r;
      SRC_NA:      v = na_r;
      SRC_NB:      v = nb_r;
      SRC_C:       v = c_r;
      SRC_T:       v = tmp_a_r;
      SRC_U:       v = tmp_b_r;
      SRC_T_RND:   v = tmp_a_r << 17;
      SRC_D_X2:    v = d_r << 1;
      SRC_SXX_SC:  v = ext_sum(sum_r[SUM_SXX]) << (WEIGHT_FRAC_BITS + 32);
      SRC_S_SC:    v = ext_sum(sum_r[SUM_S]) << (WEIGHT_FRAC_BITS + 32);
      SRC_C_SC:    v = c_r << 16;
      SRC_D_SC:    v = d_r << WEIGHT_FRAC_BITS;
      SRC_NM2:     v = {{(FIT_W-CNT_W){1'b0}}, cnt_r - CNT_W'(2)};
      SRC_T_SAT64: v = (|tmp_a_r[FIT_W-1:64]) ? {{(FIT_W-64){1'b0}}, {64{1'b1}}}
                                              : {{(FIT_W-64){1'b0}}, tmp_a_r[63:0]};
      default:     v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_round(input logic [FIT_W-1:0] q, input logic neg);
    logic [31:0] mag;
    if (!neg) begin
      mag = (|q[FIT_W-1:31]) ? 32'h7FFF_FFFF : q[31:0];
      return mag;
    end
    mag = ((|q[FIT_W-1:32]) || (q[31] && (|q[30:0]))) ? 32'h8000_0000 : q[31:0];
    return ~mag + 32'd1;
  endfunction

  assign uop           = ucode(pc_r);
  assign alu_req.start = (state_r == ST_ISSUE);
  assign alu_req.op    = uop.op;
  assign alu_a         = src_val(uop.a);
  assign alu_b         = src_val(uop.b);

  wlf_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .stat   (alu_st),
    .result (alu_res)
  );

  // point datapath multiplier
  always_comb begin
    pm_a = '0;
    pm_b = '0;
    case (state_r)
      ST_SQ: begin
        pm_a = {{(PMA_W-16){1'b0}}, uv_r};
        pm_b = {{(PMB_W-16){1'b0}}, uv_r};
      end
      ST_PROD: begin
        pm_a = (step_r == STEP_W'(2)) ? {{(PMA_W-16){yv_r[15]}}, yv_r}
                                      : {{(PMA_W-16){xv_r[15]}}, xv_r};
        pm_b = (step_r == STEP_W'(0)) ? {{(PMB_W-16){xv_r[15]}}, xv_r}
                                      : {{(PMB_W-16){yv_r[15]}}, yv_r};
      end
      ST_ACC: begin
        pm_a = {{(PMA_W-WQ_W){1'b0}}, wq_r};
        case (step_r[2:0])
          3'd0:    pm_b = {{(PMB_W-16){xv_r[15]}}, xv_r};
          3'd1:    pm_b = {{(PMB_W-16){yv_r[15]}}, yv_r};
          3'd2:    pm_b = xx_r;
          3'd3:    pm_b = xy_r;
          default: pm_b = yy_r;
        endcase
      end
      default: ;
    endcase
    pm_p = pm_a * pm_b;
  end

  assign wnum    = (32'd1 << WEIGHT_FRAC_BITS) + {1'b0, u2_r[31:1]};
  assign wsh     = {wrem_r, wq_r[WQ_W-1]};
  assign wdf     = {1'b0, wsh} - {2'b00, u2_r};
  assign acc_idx = step_r[2:0];
  assign full    = (cnt_r == CNT_W'(MAX_POINTS));
  assign fit_ok  = (cnt_r >= CNT_W'(3)) && !d_r[FIT_W-1] && (d_r != '0);
  assign out_load = (state_r == ST_OUT) && (!ov_r || out_fit.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_pt.valid) begin
          if (full) state_nxt = in_pt.end_of_event ? ST_ISSUE : ST_IDLE;
          else      state_nxt = ST_SQ;
        end
      end
      ST_SQ:   state_nxt = ST_PROD;
      ST_PROD: if (step_r == STEP_W'(2)) state_nxt = ST_WDIV;
      ST_WDIV: if (step_r == STEP_W'(WQ_W - 1)) state_nxt = ST_ACC;
      ST_ACC:  if (step_r == STEP_W'(5)) state_nxt = eoe_r ? ST_ISSUE : ST_IDLE;
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (alu_st.done) state_nxt = (pc_r == PC_W'(PROG_LEN - 1)) ? ST_OUT : ST_ISSUE;
      end
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      pc_r    <= '0;
      cnt_r   <= '0;
      evt_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < SUM_N; i++) sum_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load)           ov_r <= 1'b1;
      else if (out_fit.ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_pt.valid) begin
            xv_r   <= in_pt.x_value;
            yv_r   <= in_pt.y_value;
            uv_r   <= (in_pt.y_uncertainty == 16'd0) ? 16'd1 : in_pt.y_uncertainty;
            eoe_r  <= in_pt.end_of_event;
            step_r <= '0;
            if (!full) cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_SQ: u2_r <= pm_p[31:0];
        ST_PROD: begin
          case (step_r[1:0])
            2'd0:    xx_r <= pm_p[PMB_W-1:0];
            2'd1:    xy_r <= pm_p[PMB_W-1:0];
            default: yy_r <= pm_p[PMB_W-1:0];
          endcase
          if (step_r == STEP_W'(2)) begin
            wrem_r <= wnum >> WQ_W;
            wq_r   <= wnum[WQ_W-1:0];
            step_r <= '0;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_WDIV: begin
          wrem_r <= wdf[33] ? wsh[31:0] : wdf[31:0];
          wq_r   <= {wq_r[WQ_W-2:0], ~wdf[33]};
          step_r <= (step_r == STEP_W'(WQ_W - 1)) ? '0 : step_r + STEP_W'(1);
        end
        ST_ACC: begin
          if (step_r != STEP_W'(5)) prod_r <= pm_p;
          if (step_r == STEP_W'(0)) begin
            sum_r[SUM_S] <= sum_r[SUM_S] + {{(SUM_W-WQ_W){1'b0}}, wq_r};
          end else begin
            sum_r[acc_idx] <= sum_r[acc_idx]
                              + {{(SUM_W-PRD_W){prod_r[PRD_W-1]}}, prod_r};
          end
          step_r <= (step_r == STEP_W'(5)) ? '0 : step_r + STEP_W'(1);
        end
        ST_ISSUE: ;
        ST_WAIT: begin
          if (alu_st.done) begin
            case (uop.dst)
              DST_T:   tmp_a_r <= alu_res;
              DST_U:   tmp_b_r <= alu_res;
              DST_D:   d_r     <= alu_res;
              DST_NA:  na_r    <= alu_res;
              DST_NB:  nb_r    <= alu_res;
              DST_C:   c_r     <= alu_res;
              DST_INT: ia_r    <= sat_round(alu_res, na_r[FIT_W-1]);
              DST_SLP: sl_r    <= sat_round(alu_res, nb_r[FIT_W-1]);
              DST_ERA: ea_r    <= sum_r[SUM_SXX][SUM_W-1] ? 32'd0 : alu_res[31:0];
              DST_ERB: eb_r    <= sum_r[SUM_S][SUM_W-1] ? 32'd0 : alu_res[31:0];
              DST_CHI: begin
                if (c_r[FIT_W-1])          chi_r <= '0;
                else if (|alu_res[FIT_W-1:40]) chi_r <= '1;
                else                       chi_r <= alu_res[39:0];
              end
              default: ;
            endcase
            if (pc_r != PC_W'(PROG_LEN - 1)) pc_r <= pc_r + PC_W'(1);
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_fit.intercept       <= fit_ok ? ia_r : '0;
            out_fit.slope           <= fit_ok ? sl_r : '0;
            out_fit.intercept_error <= fit_ok ? ea_r : '0;
            out_fit.slope_error     <= fit_ok ? eb_r : '0;
            out_fit.chi2_per_dof    <= fit_ok ? chi_r : '0;
            out_fit.event_number    <= evt_r;
            out_fit.points_in_event <= cnt_r;
            out_fit.fit_valid       <= fit_ok;
            for (int i = 0; i < SUM_N; i++) sum_r[i] <= '0;
            cnt_r <= '0;
            evt_r <= evt_r + 16'd1;
            pc_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_pt.ready   = (state_r == ST_IDLE);
  assign out_fit.valid = ov_r;

  a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_pt.ready |-> !alu_st.busy) else $error("point taken while wide unit busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_st.done |-> state_r == ST_WAIT) else $error("wide unit result outside wait");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_fit.valid) |-> $past(state_r == ST_OUT)) else $error("result without fit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS)) else $error("point count beyond limit");

endmodule

// File: dv/wlf_checker.sv
// checker for weighted_line_fit: watches the point and fit channels, predicts each fit
// exactly in wide integer arithmetic and compares field by field; depends on wlf_pkg, wlf_if
module wlf_checker import wlf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  wlf_in_if    mon_in,
  wlf_out_if   mon_out,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [271:0] wide_t;

  typedef struct {
    logic [31:0]      intercept;
    logic [31:0]      slope;
    logic [31:0]      intercept_error;
    logic [31:0]      slope_error;
    logic [39:0]      chi2_per_dof;
    logic [15:0]      event_number;
    logic [CNT_W-1:0] points_in_event;
    logic             fit_valid;
  } fit_t;

  fit_t fit_queue[$];

  logic signed [63:0] s_w, s_wx, s_wy, s_wxx, s_wxy, s_wyy;
  logic [CNT_W-1:0]   npts;
  logic [15:0]        event_idx;

  assign pending = fit_queue.size();

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic wide_t clip64(wide_t v);
    return (v > wide_t'(64'hFFFF_FFFF_FFFF_FFFF)) ? wide_t'(64'hFFFF_FFFF_FFFF_FFFF) : v;
  endfunction

  // rounded quotient, halves away from zero, saturated to signed 32 bits
  function automatic logic [31:0] rounded_q16(wide_t num, wide_t den);
    wide_t mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< 17) + den) / (den <<< 1);
    if (num < 0) begin
      if (q > wide_t'(64'h8000_0000)) q = wide_t'(64'h8000_0000);
      return 32'(-q);
    end
    if (q > wide_t'(64'h7FFF_FFFF)) q = wide_t'(64'h7FFF_FFFF);
    return 32'(q);
  endfunction

  function automatic logic [31:0] std_error(wide_t v, wide_t den);
    logic [63:0] r;
    if (v < 0) return 0;
    r = root64(64'(clip64((v <<< (WEIGHT_FRAC_BITS + 32)) / den)));
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(r);
  endfunction

  function automatic fit_t solve_line();
    fit_t f;
    wide_t s, sx, sy, sxx, sxy, syy, d, na, nb, c, q;
    s = s_w; sx = s_wx; sy = s_wy; sxx = s_wxx; sxy = s_wxy; syy = s_wyy;
    f = '{default: '0};
    f.event_number = event_idx;
    f.points_in_event = npts;
    d = s * sxx - sx * sx;
    if (npts >= 3 && d > 0) begin
      na = sxx * sy - sx * sxy;
      nb = s * sxy - sx * sy;
      f.intercept = rounded_q16(na, d);
      f.slope = rounded_q16(nb, d);
      f.intercept_error = std_error(sxx, d);
      f.slope_error = std_error(s, d);
      c = syy * d - na * sy - nb * sxy;
      if (c > 0) begin
        q = clip64((c <<< 16) / ((d <<< WEIGHT_FRAC_BITS) * wide_t'(npts - 2)));
        f.chi2_per_dof = (q > wide_t'(40'hFF_FFFF_FFFF)) ? 40'hFF_FFFF_FFFF : 40'(q);
      end
      f.fit_valid = 1'b1;
    end
    return f;
  endfunction

  task automatic compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [63:0]        u, u2, w;
    logic signed [63:0] xs, ys;
    fit_t               e;
    if (!rst_n) begin
      s_w = 0; s_wx = 0; s_wy = 0; s_wxx = 0; s_wxy = 0; s_wyy = 0;
      npts = 0;
      event_idx = 0;
      fit_queue.delete();
      fail_count = 0;
    end else begin
      if (mon_in.valid && mon_in.ready) begin
        u = (mon_in.y_uncertainty == 0) ? 64'd1 : 64'(mon_in.y_uncertainty);
        xs = mon_in.x_value;
        ys = mon_in.y_value;
        if (npts < MAX_POINTS) begin
          u2 = u * u;
          w = ((64'd1 << WEIGHT_FRAC_BITS) + (u2 >> 1)) / u2;
          s_w = s_w + w;
          s_wx = s_wx + w * xs;
          s_wy = s_wy + w * ys;
          s_wxx = s_wxx + w * (xs * xs);
          s_wxy = s_wxy + w * (xs * ys);
          s_wyy = s_wyy + w * (ys * ys);
          npts = npts + 1;
        end
        if (mon_in.end_of_event) begin
          fit_queue.push_back(solve_line());
          s_w = 0; s_wx = 0; s_wy = 0; s_wxx = 0; s_wxy = 0; s_wyy = 0;
          npts = 0;
          event_idx = event_idx + 1;
        end
      end
      if (mon_out.valid && mon_out.ready) begin
        if (fit_queue.size() == 0) begin
          $error("fit transaction with nothing expected");
          fail_count++;
        end else begin
          e = fit_queue.pop_front();
          compare("intercept", 64'(e.intercept), 64'(unsigned'(mon_out.intercept)));
          compare("slope", 64'(e.slope), 64'(unsigned'(mon_out.slope)));
          compare("intercept_error", 64'(e.intercept_error), 64'(mon_out.intercept_error));
          compare("slope_error", 64'(e.slope_error), 64'(mon_out.slope_error));
          compare("chi2_per_dof", 64'(e.chi2_per_dof), 64'(mon_out.chi2_per_dof));
          compare("event_number", 64'(e.event_number), 64'(mon_out.event_number));
          compare("points_in_event", 64'(e.points_in_event), 64'(mon_out.points_in_event));
          compare("fit_valid", 64'(e.fit_valid), 64'(mon_out.fit_valid));
        end
      end
    end
  end
endmodule

// File: dv/testbench.sv
// top of the weighted_line_fit testbench: clock, reset, point stimulus, fit-side stalls
// and verdict; depends on wlf_pkg, wlf_if and wlf_checker
module testbench import wlf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 40000;

  logic clk = 0;
  logic rst_n = 0;
  logic calm = 0;
  logic pt_taken = 0;
  int   fail_count, pending, quiet;

  wlf_in_if  in_ch();
  wlf_out_if out_ch();

  weighted_line_fit uut (.clk(clk), .rst_n(rst_n), .in_pt(in_ch), .out_fit(out_ch));
  wlf_checker chk (.clk(clk), .rst_n(rst_n), .mon_in(in_ch), .mon_out(out_ch),
                   .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  always @(posedge clk) pt_taken <= in_ch.valid && in_ch.ready;

  always @(negedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 27);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("weighted_line_fit verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] u, logic eoe);
    if (!calm && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_ch.x_value <= x;
    in_ch.y_value <= y;
    in_ch.y_uncertainty <= u;
    in_ch.end_of_event <= eoe;
    in_ch.valid <= 1'b1;
    do @(negedge clk); while (!pt_taken);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(200)) - 16'd100;
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(4000)) - 16'd2000;
    endcase
  endfunction

  function automatic logic [15:0] pick_unc();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(300));
      default: return 16'($urandom_range(20, 1));
    endcase
  endfunction

  initial begin
    int n, sent;
    in_ch.valid = 0;
    in_ch.x_value = 0;
    in_ch.y_value = 0;
    in_ch.y_uncertainty = 0;
    in_ch.end_of_event = 0;
    out_ch.ready = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, zero and unit uncertainty
    send_point(16'h8000, 16'h8000, 16'd0, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 16'd1, 1'b0);
    send_point(16'h0000, 16'h8000, 16'hFFFF, 1'b0);
    send_point(16'h5555, 16'hAAAA, 16'h8000, 1'b1);
    // lone point and a pair
    send_point(16'd10, 16'd20, 16'd3, 1'b1);
    send_point(16'd1, 16'd2, 16'd1, 1'b0);
    send_point(16'd2, 16'd5, 16'd1, 1'b1);
    // all x equal gives a zero determinant
    send_point(16'd7, 16'd1, 16'd2, 1'b0);
    send_point(16'd7, 16'd9, 16'd5, 1'b0);
    send_point(16'd7, 16'hFFF0, 16'd1, 1'b1);
    // weights rounding to zero
    send_point(16'd1, 16'd1, 16'hFFFF, 1'b0);
    send_point(16'd2, 16'd3, 16'h4000, 1'b0);
    send_point(16'd3, 16'd5, 16'h0400, 1'b1);
    // exact line, then steep line of extremes
    send_point(16'hFFFF, 16'd3, 16'd1, 1'b0);
    send_point(16'd0, 16'd5, 16'd1, 1'b0);
    send_point(16'd1, 16'd7, 16'd1, 1'b0);
    send_point(16'd2, 16'd9, 16'd1, 1'b1);
    send_point(16'hFFFF, 16'h8000, 16'd1, 1'b0);
    send_point(16'd0, 16'h0000, 16'd1, 1'b0);
    send_point(16'd1, 16'h7FFF, 16'd1, 1'b1);

    sent = 0;
    while (sent < 800) begin
      calm = (sent >= 300 && sent < 450);
      n = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
      for (int i = 0; i < n; i++)
        send_point(pick_coord(), pick_coord(), pick_unc(), i == n - 1);
      sent += n;
    end
    calm = 0;

    // overfull event: points past the limit are dropped, the end mark still closes it
    for (int i = 0; i < MAX_POINTS + 6; i++)
      send_point(pick_coord(), pick_coord(), pick_unc(), i == MAX_POINTS + 5);
    send_point(16'd4, 16'd4, 16'd1, 1'b1);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("weighted_line_fit verification clean");
    end else begin
      $display("weighted_line_fit verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
design/wlf_pkg.sv
design/wlf_if.sv
design/wlf_alu.sv
design/weighted_line_fit.sv
dv/wlf_checker.sv
dv/testbench.sv
